// File: src/pn_pkg.sv
package pn_pkg;

  // default number of fraction bits of the gain word
  localparam int unsigned GainFracBitsDef = 12;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned TargetW = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] RegTargetPeak = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxGain    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegUnityThr   = 2'd2;

  localparam logic [TargetW-1:0] TargetPeakRst = 15'd31129;
  localparam logic [GainW-1:0]   MaxGainRst    = 16'd24576;
  localparam logic [GainW-1:0]   UnityThrRst   = 16'd4100;

  // one finished output word
  typedef struct packed {
    logic               clipped;
    logic               gain_used;
    logic               last_out;
    logic [SampleW-1:0] sample_out;
  } pn_res_t;

endpackage

// File: src/peak_normalizer.sv
// Two-pass peak normalizer for signed 16-bit audio. Each clip is streamed twice: in the
// measure pass (tuser = 0) the largest sample magnitude is tracked, and the word flagged
// tlast computes the clip gain target_peak * 2^GAIN_FRAC_BITS / peak (truncated, capped at
// max_gain, unsigned with GAIN_FRAC_BITS fraction bits) and resets the peak tracker to 1.
// Measure words produce no output. In the apply pass (tuser = 1) each word yields one
// output word: the sample times the gain, truncated toward zero and saturated to 16 bits,
// or the sample unchanged when the gain is at or below unity_threshold. A measure word
// other than the last leaves the block ready; an apply word is multiplied into the product
// register, then saturated into the output register once no waiting output word holds it
// back; the last measure word waits for the restoring divider, one quotient bit per cycle.
// The block takes one word at a time. Config registers must be written only while idle;
// the block itself does not enforce this. Before any measure pass the gain is unity.
module peak_normalizer import pn_pkg::*; #(
  parameter int unsigned GAIN_FRAC_BITS = GainFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [SampleW-1:0] s_axis_tdata,   // [15:0] sample_in
  input  logic               s_axis_tuser,   // [0] mode
  input  logic               s_axis_tlast,
  // output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [SampleW-1:0] m_axis_tdata,   // [15:0] sample_out
  output logic [1:0]         m_axis_tuser,   // [0] gain_used, [1] clipped
  output logic               m_axis_tlast,
  // config writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // numerator width of the gain division
  localparam int unsigned NumW = TargetW + GAIN_FRAC_BITS;

  // unity gain, capped to the gain word
  localparam logic [GainW:0]   UnityFull = (GainW + 1)'(1) << GAIN_FRAC_BITS;
  localparam logic [GainW-1:0] UnityGain = (GAIN_FRAC_BITS >= GainW) ? '1
                                                                      : UnityFull[GainW-1:0];

  // sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;

  logic [1:0]         state_q, state_d;

  logic [TargetW-1:0] target_q;
  logic [GainW-1:0]   max_gain_q;
  logic [GainW-1:0]   thresh_q;

  logic [SampleW-1:0] peak_q, peak_d;
  logic [GainW-1:0]   gain_q, gain_d;

  logic               out_vld_q, out_vld_d;
  pn_res_t            out_q;

  logic               in_acc;
  logic               meas_acc;
  logic               apply_acc;
  logic               div_start;
  logic [SampleW-1:0] mag;
  logic [SampleW-1:0] peak_new;
  logic               div_done;
  logic [NumW-1:0]    quotient;
  logic [GainW-1:0]   gain_cap;
  logic               out_load;
  pn_res_t            scale_res;

  // ---------------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TargetPeakRst;
      max_gain_q <= MaxGainRst;
      thresh_q   <= UnityThrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTargetPeak: target_q   <= cfg_data_i[TargetW-1:0];
        RegMaxGain:    max_gain_q <= cfg_data_i;
        RegUnityThr:   thresh_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input side: one word at a time
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign meas_acc      = in_acc && !s_axis_tuser;
  assign apply_acc     = in_acc && s_axis_tuser;
  assign div_start     = meas_acc && s_axis_tlast;

  // magnitude, most negative sample kept as 32768
  assign mag      = s_axis_tdata[SampleW-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
  assign peak_new = (mag > peak_q) ? mag : peak_q;

  // gain cap, the quotient is at least as wide as the gain word when GAIN_FRAC_BITS >= 1
  assign gain_cap = (quotient > NumW'(max_gain_q)) ? max_gain_q : quotient[GainW-1:0];

  // ---------------------------------------------------------------------------
  // divider for the per-clip gain
  // ---------------------------------------------------------------------------
  pn_div #(
    .NumW (NumW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({target_q, GAIN_FRAC_BITS'(0)}),
    .divisor_i  (peak_new),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // ---------------------------------------------------------------------------
  // scaling datapath: product register, then saturate into the output register
  // ---------------------------------------------------------------------------
  pn_scale #(
    .GainFracBits (GAIN_FRAC_BITS)
  ) u_scale (
    .clk_i    (clk_i),
    .load_i   (apply_acc),
    .sample_i (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .gain_i   (gain_q),
    .thresh_i (thresh_q),
    .res_o    (scale_res)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign out_load = (state_q == StMul) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    peak_d  = peak_q;
    gain_d  = gain_q;
    case (state_q)
      StIdle: begin
        if (meas_acc) begin
          // peak goes back to 1 once the last word hands it to the divider
          peak_d = s_axis_tlast ? SampleW'(1) : peak_new;
        end
        if (div_start) begin
          state_d = StDiv;
        end else if (apply_acc) begin
          state_d = StMul;
        end
      end
      StMul: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      StDiv: begin
        if (div_done) begin
          gain_d  = gain_cap;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      peak_q    <= SampleW'(1);
      gain_q    <= UnityGain;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      peak_q    <= peak_d;
      gain_q    <= gain_d;
      out_vld_q <= out_vld_d;
    end
  end

  // output word holds until taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= scale_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.sample_out;
  assign m_axis_tlast  = out_q.last_out;
  assign m_axis_tuser  = {out_q.clipped, out_q.gain_used};

endmodule

// File: src/pn_div.sv
module pn_div import pn_pkg::*; #(
  parameter int unsigned NumW = 27
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumW-1:0]    dividend_i,
  input  logic [SampleW-1:0] divisor_i,
  output logic               done_o,
  output logic [NumW-1:0]    quotient_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [SampleW-1:0] rem_q, rem_d;
  logic [SampleW-1:0] dvs_q, dvs_d;
  logic [NumW-1:0]    quo_q, quo_d;

  logic [SampleW:0]   trial;
  logic [SampleW:0]   diff;
  logic               ge;

  // one restoring step per cycle, dividend shifts out msb first
  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[SampleW-1:0] : trial[SampleW-1:0];
      quo_d = {quo_q[NumW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: src/pn_scale.sv
module pn_scale import pn_pkg::*; #(
  parameter int unsigned GainFracBits = GainFracBitsDef
) (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic               last_i,
  input  logic [GainW-1:0]   gain_i,
  input  logic [GainW-1:0]   thresh_i,
  output pn_res_t            res_o
);

  localparam int unsigned ProdW = SampleW + GainW;

  logic [SampleW-1:0] mag;
  logic [ProdW-1:0]   prod_q;
  logic [SampleW-1:0] samp_q;
  logic               last_q;
  logic               used_q;
  logic [ProdW-1:0]   q;
  logic               neg;
  logic               sat;
  logic [SampleW-1:0] qn;

  // magnitude of the most negative sample wraps to 0x8000, which is right unsigned
  assign mag = sample_i[SampleW-1] ? (~sample_i + 1'b1) : sample_i;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= ProdW'(mag) * ProdW'(gain_i);
      samp_q <= sample_i;
      last_q <= last_i;
      used_q <= gain_i > thresh_i;
    end
  end

  assign q   = prod_q >> GainFracBits;
  assign neg = samp_q[SampleW-1];
  assign sat = neg ? (q > ProdW'(32768)) : (q > ProdW'(32767));
  assign qn  = q[SampleW-1:0];

  always_comb begin
    res_o.last_out   = last_q;
    res_o.gain_used  = used_q;
    res_o.clipped    = 1'b0;
    res_o.sample_out = samp_q;
    if (used_q) begin
      res_o.clipped = sat;
      if (sat) begin
        res_o.sample_out = neg ? 16'h8000 : 16'h7fff;
      end else begin
        res_o.sample_out = neg ? (~qn + 1'b1) : qn;
      end
    end
  end

endmodule

// File: dv/tb_peak_normalizer.sv
`timescale 1ns / 100ps

module tb_peak_normalizer;
  import pn_pkg::*;

  localparam int FracBits   = GainFracBitsDef;
  localparam int NumWords   = 2000;   // input words before the stimulus stops
  localparam int CalmWords  = 150;    // tail of the run with no idling on either side
  localparam int DrainGap   = 64;     // covers the gain divide of a last measure word
  localparam int HoldCycles = 300;    // long output back-pressure stretch
  localparam int HoldAt     = 600;    // input word count that triggers it
  localparam int StuckLimit = 4000;   // cycles without any handshake before giving up
  localparam int MaxClipLen = 64;     // longest random clip

  // pass selector carried on s_axis_tuser
  typedef enum logic {PASS_MEASURE = 1'b0, PASS_APPLY = 1'b1} pass_e;
  typedef enum logic [1:0] {ROW_MEASURE, ROW_APPLY, ROW_REG} row_e;

  // one step of the directed script: a word (val is the sample) or a register write
  typedef struct packed {
    row_e               kind;
    logic [CfgIdxW-1:0] idx;
    logic [15:0]        val;
    logic               last;
    logic               typed;   // want holds the expected output word
    pn_res_t            want;    // clipped, gain_used, last_out, sample_out
  } script_row_t;

  localparam script_row_t Script [27] = '{
    // unity gain after reset sits below the threshold: plain pass-through
    '{ROW_APPLY,   '0,            16'h7fff, 1'b0, 1'b1, {1'b0, 1'b0, 1'b0, 16'h7fff}},
    '{ROW_APPLY,   '0,            16'h8000, 1'b1, 1'b1, {1'b0, 1'b0, 1'b1, 16'h8000}},
    // most negative sample sets a peak of 32768, gain lands under the threshold
    '{ROW_MEASURE, '0,            16'h0064, 1'b0, 1'b0, '0},
    '{ROW_MEASURE, '0,            16'h8000, 1'b0, 1'b0, '0},
    '{ROW_MEASURE, '0,            16'h0005, 1'b1, 1'b0, '0},
    '{ROW_APPLY,   '0,            16'h03e8, 1'b0, 1'b1, {1'b0, 1'b0, 1'b0, 16'h03e8}},
    // peak of 1: gain hits the cap of 6.0, full-scale samples saturate
    '{ROW_MEASURE, '0,            16'h0001, 1'b1, 1'b0, '0},
    '{ROW_APPLY,   '0,            16'h7fff, 1'b0, 1'b1, {1'b1, 1'b1, 1'b0, 16'h7fff}},
    '{ROW_APPLY,   '0,            16'h8000, 1'b0, 1'b1, {1'b1, 1'b1, 1'b0, 16'h8000}},
    '{ROW_APPLY,   '0,            16'h0000, 1'b0, 1'b1, {1'b0, 1'b1, 1'b0, 16'h0000}},
    '{ROW_APPLY,   '0,            16'hffff, 1'b0, 1'b1, {1'b0, 1'b1, 1'b0, 16'hfffa}},
    '{ROW_APPLY,   '0,            16'h1555, 1'b1, 1'b0, '0},
    // all-zero measure pass keeps the peak at 1
    '{ROW_MEASURE, '0,            16'h0000, 1'b1, 1'b0, '0},
    // widest cap
    '{ROW_REG,     RegMaxGain,    16'hffff, 1'b0, 1'b0, '0},
    '{ROW_MEASURE, '0,            16'h0001, 1'b1, 1'b0, '0},
    '{ROW_APPLY,   '0,            16'h0001, 1'b0, 1'b0, '0},
    '{ROW_APPLY,   '0,            16'hfffd, 1'b1, 1'b0, '0},
    // zero target gives zero gain, so samples pass through
    '{ROW_REG,     RegTargetPeak, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_MEASURE, '0,            16'h7fff, 1'b1, 1'b0, '0},
    '{ROW_APPLY,   '0,            16'hcfc7, 1'b1, 1'b1, {1'b0, 1'b0, 1'b1, 16'hcfc7}},
    // full target, zero threshold
    '{ROW_REG,     RegTargetPeak, 16'h7fff, 1'b0, 1'b0, '0},
    '{ROW_REG,     RegUnityThr,   16'h0000, 1'b0, 1'b0, '0},
    '{ROW_MEASURE, '0,            16'h4000, 1'b1, 1'b0, '0},
    '{ROW_APPLY,   '0,            16'h4e20, 1'b0, 1'b0, '0},
    '{ROW_APPLY,   '0,            16'h8001, 1'b0, 1'b0, '0},
    // gain exactly at the threshold still passes through
    '{ROW_REG,     RegUnityThr,   16'h1fff, 1'b0, 1'b0, '0},
    '{ROW_APPLY,   '0,            16'h7fff, 1'b1, 1'b1, {1'b0, 1'b0, 1'b1, 16'h7fff}}
  };

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [SampleW-1:0] s_axis_tdata  = '0;    // [15:0] sample_in
  logic               s_axis_tuser  = 1'b0;  // [0] mode
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [SampleW-1:0] m_axis_tdata;          // [15:0] sample_out
  logic [1:0]         m_axis_tuser;          // [0] gain_used, [1] clipped
  logic               m_axis_tlast;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [CfgW-1:0]    cfg_data_i    = '0;

  peak_normalizer u_top (.*);

  // predictor copy of the registers and the clip state
  logic [TargetW-1:0] tgt_peak  = TargetPeakRst;
  logic [GainW-1:0]   gain_cap  = MaxGainRst;
  logic [GainW-1:0]   unity_thr = UnityThrRst;
  logic [GainW-1:0]   clip_gain = GainW'(1 << FracBits);
  logic [15:0]        peak_mag  = 16'd1;

  pn_res_t expected_out [$];

  int unsigned words_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned outs_seen    = 0;
  int unsigned outs_scaled  = 0;
  int unsigned outs_clipped = 0;
  int unsigned stuck_cycles = 0;
  bit          calm         = 1'b0;
  bit          hold_out     = 1'b0;

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // track the peak / derive the gain for measure words, scale apply words;
  // returns 1 when the word produces an output word
  function automatic bit normalize_word(input pass_e pass, input logic [15:0] smp,
                                        input logic lst, output pn_res_t res);
    logic [15:0] mag;
    logic [63:0] quo;
    logic [63:0] scaled;
    mag = smp[15] ? (~smp + 16'd1) : smp;   // 0x8000 stays 32768
    res = '0;
    if (pass == PASS_MEASURE) begin
      if (mag > peak_mag) peak_mag = mag;
      if (lst) begin
        quo       = (64'(tgt_peak) << FracBits) / 64'(peak_mag);
        clip_gain = (quo > 64'(gain_cap)) ? gain_cap : quo[GainW-1:0];
        peak_mag  = 16'd1;
      end
      return 1'b0;
    end
    res.last_out   = lst;
    res.sample_out = smp;
    if (clip_gain > unity_thr) begin
      scaled        = (64'(mag) * 64'(clip_gain)) >> FracBits;   // truncates toward zero
      res.gain_used = 1'b1;
      if (!smp[15]) begin
        if (scaled > 64'd32767) begin
          res.sample_out = 16'h7fff;
          res.clipped    = 1'b1;
        end else begin
          res.sample_out = scaled[15:0];
        end
      end else begin
        if (scaled > 64'd32768) begin
          res.sample_out = 16'h8000;
          res.clipped    = 1'b1;
        end else begin
          res.sample_out = ~scaled[15:0] + 16'd1;
        end
      end
    end
    return 1'b1;
  endfunction

  // offer one word, wait for the handshake, then log what it should produce
  task automatic send_word(input pass_e pass, input logic [15:0] smp, input logic lst,
                           input logic typed, input pn_res_t want);
    pn_res_t calc;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= pass;
    s_axis_tlast  <= lst;
    // tready is settled mid-cycle; the word moves at the following edge
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    words_sent++;
    if (words_sent == HoldAt) hold_out = 1'b1;
    calm = (words_sent >= NumWords - CalmWords);
    if (normalize_word(pass, smp, lst, calc))
      expected_out = {expected_out, (typed ? want : calc)};
  endtask

  // stop offering, wait for every expected word, then give the divider time to finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegTargetPeak: tgt_peak  = val[TargetW-1:0];
      RegMaxGain:    gain_cap  = val;
      RegUnityThr:   unity_thr = val;
      default: ;
    endcase
  endtask

  // extremes, reset values and random settings
  function automatic logic [CfgW-1:0] pick_reg_value(input logic [CfgIdxW-1:0] idx);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return (idx == RegTargetPeak) ? 16'h7fff : 16'hffff;
      2: begin
        case (idx)
          RegTargetPeak: return CfgW'(TargetPeakRst);
          RegMaxGain:    return MaxGainRst;
          default:       return UnityThrRst;
        endcase
      end
      default: begin
        case (idx)
          RegTargetPeak: return CfgW'($urandom_range(0, 32767));
          RegMaxGain:    return CfgW'($urandom_range(0, 65535));
          default:       return CfgW'($urandom_range(0, 8192));
        endcase
      end
    endcase
  endfunction

  // one clip the way software streams it: measure pass, then the same samples
  // again in the apply pass, with a few apply words swapped for full-range noise
  task automatic run_clip();
    logic signed [15:0] clip_data [MaxClipLen];
    logic signed [15:0] smp;
    int unsigned        len;
    int unsigned        span;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, MaxClipLen) : $urandom_range(1, 24);
    span = $urandom_range(1, 16);   // significant bits of the clip's samples
    for (int i = 0; i < len; i++) begin
      smp = 16'($urandom);
      smp = smp <<< (16 - span);
      smp = smp >>> (16 - span);
      clip_data[i] = smp;
    end
    for (int i = 0; i < len; i++)
      send_word(PASS_MEASURE, clip_data[i], i == len - 1, 1'b0, '0);
    for (int i = 0; i < len; i++) begin
      smp = ($urandom_range(0, 4) == 0) ? 16'($urandom) : clip_data[i];
      send_word(PASS_APPLY, smp, i == len - 1, 1'b0, '0);
    end
  endtask

  // broken sequences: random passes, stray or missing last flags
  task automatic run_noise();
    repeat ($urandom_range(4, 32))
      send_word(pass_e'($urandom_range(0, 1)), 16'($urandom), $urandom_range(0, 7) == 0,
                1'b0, '0);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed script
    for (int i = 0; i < $size(Script); i++) begin
      if (Script[i].kind == ROW_REG) begin
        settle();
        write_reg(Script[i].idx, Script[i].val);
      end else begin
        send_word(Script[i].kind == ROW_APPLY ? PASS_APPLY : PASS_MEASURE, Script[i].val,
                  Script[i].last, Script[i].typed, Script[i].want);
      end
    end

    // random phases, registers only touched while the block is idle
    while (words_sent < NumWords) begin
      settle();
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1)) write_reg(RegTargetPeak, pick_reg_value(RegTargetPeak));
        if ($urandom_range(0, 1)) write_reg(RegMaxGain, pick_reg_value(RegMaxGain));
        if ($urandom_range(0, 1)) write_reg(RegUnityThr, pick_reg_value(RegUnityThr));
      end
      if ($urandom_range(0, 6) == 0) run_noise();
      else repeat ($urandom_range(1, 3)) run_clip();
    end

    settle();
    $display("covered %0d input words and %0d output words", words_sent, outs_seen);
    $display("of those %0d scaled, %0d saturated, %0d passed through",
             outs_scaled, outs_clipped, outs_seen - outs_scaled);
    if (mismatches == 0) begin
      $display("peak_normalizer regression: pass");
    end else begin
      $display("peak_normalizer regression: fail");
    end
    $finish;
  end

  // output side: random stalls, one long hold-off, none in the tail
  initial begin : sink
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_out) begin
        m_axis_tready <= 1'b0;
        for (int c = 0; c < HoldCycles; c++) @(posedge clk_i);
        hold_out = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // outputs only change at the rising edge, so a handshake seen mid-cycle is the
  // one taken at the next edge
  always @(negedge clk_i) begin : out_check
    pn_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_out.size() == 0) begin
        $error("output word with nothing expected: sample_out %0d", $signed(m_axis_tdata));
        mismatches++;
      end else begin
        want = expected_out.pop_front();
        outs_seen++;
        if (m_axis_tdata !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d",
                 $signed(want.sample_out), $signed(m_axis_tdata));
          mismatches++;
        end
        if (m_axis_tlast !== want.last_out) begin
          $error("last_out: expected %0b, got %0b", want.last_out, m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.gain_used) begin
          $error("gain_used: expected %0b, got %0b", want.gain_used, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, m_axis_tuser[1]);
          mismatches++;
        end
        if (want.gain_used) outs_scaled++;
        if (want.clipped) outs_clipped++;
      end
    end
  end

  // watchdog on cycles where no word moves on either side
  always @(negedge clk_i) begin : watchdog
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("timeout: no handshake for %0d cycles", StuckLimit);
        $display("peak_normalizer regression: fail");
        $finish;
      end
    end
  end

endmodule
